### rtl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  localparam int unsigned BlockCountDef = 128;
  localparam int unsigned BlockBytesDef = 512;
  localparam logic [31:0] PoolBaseRst   = 32'h0020_0000;

  localparam logic       ACT_ALLOC = 1'b0;
  localparam logic       ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_NO_SPACE      = 2'd1;
  localparam logic [1:0] ST_ZERO_SIZE     = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOCATED = 2'd3;

  typedef struct packed {
    logic        action;
    logic [16:0] size_bytes;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_address;
    logic [7:0]  granted_blocks;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       hit_alloc;
    logic       lookup;
    logic       mark_step;
    logic       clear_step;
    logic       rsp_load;
    logic [1:0] rsp_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic alloc_hit;
    logic free_match;
    logic entry_live;
    logic at_last;
    logic rem_last;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/first_fit_block_allocator.sv
// Allocate loads the request, scans up to BLOCK_COUNT blocks for a run, claims its blocks
// and loads the result; free loads, scans, reads the run length, clears the run, responds.
// Throughput: one request in flight; the block-use walk, one entry a cycle, sets the rate.
// A new request is taken while the last result beat still waits in the output register.
// Reset (rst_ni low, asynchronous) empties the pool at once and sets pool_base to 0x200000.
`default_nettype none

module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = BlockCountDef,
  parameter int unsigned BLOCK_BYTES = BlockBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire req_t        in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rsp_t             out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffba_dp #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

### rtl/ffba_ctrl.sv
`default_nettype none

module ffba_ctrl
  import ffba_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOOKUP,
    S_MARK,
    S_CLEAR,
    S_RESP
  } state_e;

  state_e     state_q;
  logic       out_valid_q;
  logic [1:0] st_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.rsp_status = st_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      S_SCAN: begin
        if (!sts_i.is_free && sts_i.size_zero) begin
          cmd_o.step = 1'b0;
        end else if (!sts_i.is_free && sts_i.alloc_hit) begin
          cmd_o.hit_alloc = 1'b1;
        end else if (sts_i.is_free && sts_i.free_match) begin
          cmd_o.step = 1'b0;
        end else if (!sts_i.at_last) begin
          cmd_o.step = 1'b1;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
      end
      S_MARK: begin
        cmd_o.mark_step = 1'b1;
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      S_RESP: begin
        cmd_o.rsp_load = !out_valid_q || out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      st_q        <= ST_OK;
    end else begin
      if ((state_q == S_RESP) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!sts_i.is_free && sts_i.size_zero) begin
            st_q    <= ST_ZERO_SIZE;
            state_q <= S_RESP;
          end else if (!sts_i.is_free && sts_i.alloc_hit) begin
            state_q <= S_MARK;
          end else if (sts_i.is_free && sts_i.free_match) begin
            if (sts_i.entry_live) begin
              state_q <= S_LOOKUP;
            end else begin
              st_q    <= ST_NOT_ALLOCATED;
              state_q <= S_RESP;
            end
          end else if (sts_i.at_last) begin
            st_q    <= sts_i.is_free ? ST_NOT_ALLOCATED : ST_NO_SPACE;
            state_q <= S_RESP;
          end
        end
        S_LOOKUP: begin
          state_q <= S_CLEAR;
        end
        S_MARK, S_CLEAR: begin
          if (sts_i.rem_last) begin
            st_q    <= ST_OK;
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while idle did not start work");

  a_resp_waits_for_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rsp_load |-> (!out_valid_q || out_ready_i))
    else $error("result beat overwritten before it was taken");

  a_one_walk_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.hit_alloc, cmd_o.lookup,
              cmd_o.mark_step, cmd_o.clear_step, cmd_o.rsp_load}))
    else $error("more than one datapath command at once");

endmodule

`default_nettype wire

### rtl/ffba_dp.sv
`default_nettype none

module ffba_dp
  import ffba_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = BlockCountDef,
  parameter int unsigned BLOCK_BYTES = BlockBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire req_t        in_data_i,
  output rsp_t             out_data_o,
  input  wire dp_cmd_t     cmd_i,
  output dp_sts_t          sts_o
);

  localparam int unsigned IW   = $clog2(BLOCK_COUNT);
  localparam int unsigned CW   = $clog2(BLOCK_COUNT + 1);
  localparam int unsigned BW   = $clog2(BLOCK_COUNT * BLOCK_BYTES + 1);
  localparam int unsigned CMPW = (BW > 17) ? BW : 17;

  logic [31:0]            pool_base_q;
  logic [BLOCK_COUNT-1:0] used_q;
  logic [BLOCK_COUNT-1:0] head_q;
  logic [CW-1:0]          run_len_mem [BLOCK_COUNT];
  logic [CW-1:0]          rd_q;

  req_t          req_q;
  rsp_t          rsp_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] cur_q;
  logic [IW-1:0] start_q;
  logic [31:0]   addr_q;
  logic [31:0]   run_addr_q;
  logic [31:0]   grant_addr_q;
  logic [CW-1:0] run_cnt_q;
  logic [BW-1:0] run_bytes_q;
  logic [CW-1:0] len_q;
  logic [CW-1:0] rem_q;

  logic          free_now;
  logic [CW-1:0] cnt_n;
  logic [BW-1:0] bytes_n;
  logic          rsp_ok;

  assign free_now = !used_q[idx_q];
  assign cnt_n    = free_now ? run_cnt_q + CW'(1) : '0;
  assign bytes_n  = free_now ? run_bytes_q + BW'(BLOCK_BYTES) : '0;

  assign sts_o.is_free    = (req_q.action == ACT_FREE);
  assign sts_o.size_zero  = (req_q.size_bytes == '0);
  assign sts_o.alloc_hit  = free_now && (CMPW'(bytes_n) >= CMPW'(req_q.size_bytes));
  assign sts_o.free_match = (addr_q == req_q.free_address);
  assign sts_o.entry_live = used_q[idx_q] && head_q[idx_q];
  assign sts_o.at_last    = (idx_q == IW'(BLOCK_COUNT - 1));
  assign sts_o.rem_last   = (rem_q == CW'(1));

  assign rsp_ok     = (cmd_i.rsp_status == ST_OK);
  assign out_data_o = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= PoolBaseRst;
      used_q      <= '0;
      head_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        pool_base_q <= cfg_data_i;
      end
      if (cmd_i.mark_step) begin
        used_q[cur_q] <= 1'b1;
        head_q[cur_q] <= (cur_q == start_q);
      end else if (cmd_i.clear_step) begin
        used_q[cur_q] <= 1'b0;
        head_q[cur_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_step && (cur_q == start_q)) begin
      run_len_mem[cur_q] <= len_q;
    end
    rd_q <= run_len_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q       <= in_data_i;
      idx_q       <= '0;
      addr_q      <= pool_base_q;
      run_addr_q  <= pool_base_q;
      run_cnt_q   <= '0;
      run_bytes_q <= '0;
    end
    if (cmd_i.step) begin
      idx_q       <= idx_q + IW'(1);
      addr_q      <= addr_q + 32'(BLOCK_BYTES);
      run_cnt_q   <= cnt_n;
      run_bytes_q <= bytes_n;
      if (!free_now) begin
        run_addr_q <= addr_q + 32'(BLOCK_BYTES);
      end
    end
    if (cmd_i.hit_alloc) begin
      start_q      <= idx_q - IW'(run_cnt_q);
      cur_q        <= idx_q - IW'(run_cnt_q);
      len_q        <= cnt_n;
      rem_q        <= cnt_n;
      grant_addr_q <= run_addr_q;
    end
    if (cmd_i.lookup) begin
      cur_q <= idx_q;
      len_q <= rd_q;
      rem_q <= rd_q;
    end
    if (cmd_i.mark_step || cmd_i.clear_step) begin
      cur_q <= cur_q + IW'(1);
      rem_q <= rem_q - CW'(1);
    end
    if (cmd_i.rsp_load) begin
      rsp_q.status          <= cmd_i.rsp_status;
      rsp_q.granted_address <= (rsp_ok && (req_q.action == ACT_ALLOC)) ? grant_addr_q : '0;
      rsp_q.granted_blocks  <= rsp_ok ? 8'(len_q) : '0;
    end
  end

  a_mark_free_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_step |-> !used_q[cur_q])
    else $error("claim marks a block that is already in use");

  a_clear_used_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_step |-> used_q[cur_q])
    else $error("release clears a block that is not in use");

  a_live_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup |-> (rd_q != '0))
    else $error("live run head holds a zero length");

  a_ok_has_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rsp_load && rsp_ok) |-> (len_q != '0))
    else $error("successful result carries no blocks");

endmodule

`default_nettype wire
